// ===== rtl/polyphonic_square_tone_mixer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tone mixer
// ---------------------------------------------------------------------------
`ifndef POLYPHONIC_SQUARE_TONE_MIXER_MACROS_SVH
`define POLYPHONIC_SQUARE_TONE_MIXER_MACROS_SVH

// implication checked on every clock outside reset
`define PSTM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define PSTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/pstm_pkg.sv =====
// ---------------------------------------------------------------------------
// pstm_pkg
// Types and constants shared by the tone mixer.
// ---------------------------------------------------------------------------
package pstm_pkg;
   localparam int HP_W = 19;
   localparam int PH_W = 20;
   localparam logic [19:0] US_PER_SECOND = 20'd1000000;
   // elapsed is 16 bits wide, so phase reduction starts at period << 16
   localparam logic [4:0] MOD_TOP_SHIFT = 5'd16;

   typedef enum logic [2:0] {
      MODE_ADD      = 3'd0,
      MODE_DELETE   = 3'd1,
      MODE_CONTAINS = 3'd2,
      MODE_CLEAR    = 3'd3,
      MODE_SAMPLE   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] freq;
      logic [15:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] sample;
      logic [3:0] note_count;
   } rsp_type;

   // command sent down the chain of cells
   typedef enum logic [2:0] {
      CMD_NONE, CMD_MATCH, CMD_SHIFT, CMD_CLEAR, CMD_ADVANCE, CMD_LOAD, CMD_REDUCE
   } cmd_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [HP_W-1:0] hp;
      logic [15:0]     elapsed;
      logic [4:0]      shift;
   } cell_ctl_type;
endpackage

// ===== rtl/pstm_div.sv =====
// ---------------------------------------------------------------------------
// pstm_div
// Restoring divider: half period = 1000000 / freq / 2, one bit a cycle.
// ---------------------------------------------------------------------------
module pstm_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [15:0]            freq,
   output logic                   done,
   output logic [pstm_pkg::HP_W-1:0] hp
);
   import pstm_pkg::*;

   logic [19:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   // one quotient bit a step, MSB first
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], US_PER_SECOND[cnt_ff]};
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         den_in  = freq;
         cnt_in  = 5'd19;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in[cnt_ff] = 1'b1;
         end else begin
            rem_in = trial;
            quot_in[cnt_ff] = 1'b0;
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign hp   = quot_ff[19:1];
endmodule

// ===== rtl/pstm_cell.sv =====
// ---------------------------------------------------------------------------
// pstm_cell
// One tone slot: half period and phase, with a neighbor link for shifts.
// ---------------------------------------------------------------------------
module pstm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  pstm_pkg::cell_ctl_type     ctl,
   input  logic                       sel,
   input  logic                       active,
   input  logic [pstm_pkg::HP_W-1:0]  next_hp,
   input  logic [pstm_pkg::PH_W-1:0]  next_ph,
   output logic [pstm_pkg::HP_W-1:0]  hp,
   output logic [pstm_pkg::PH_W-1:0]  ph,
   output logic                       match,
   output logic                       level
);
   import pstm_pkg::*;

   logic [HP_W-1:0]  hp_ff, hp_in;
   logic [PH_W-1:0]  ph_ff, ph_in;
   logic [PH_W:0]    work_ff, work_in;
   logic [PH_W:0]    per, red;
   logic [PH_W+16:0] per_sh, work_ext;

   // one compare and subtract of period << shift per reduce step
   always_comb begin
      per      = {1'b0, hp_ff, 1'b0};
      work_ext = {16'd0, work_ff};
      per_sh   = {16'd0, per} << ctl.shift;
      red      = (work_ext >= per_sh) ? work_ff - per_sh[PH_W:0] : work_ff;
   end

   always_comb begin
      hp_in   = hp_ff;
      ph_in   = ph_ff;
      work_in = work_ff;
      unique case (ctl.cmd)
         CMD_CLEAR: begin
            hp_in = '0;
            ph_in = '0;
         end
         CMD_SHIFT: if (sel) begin
            hp_in = next_hp;
            ph_in = next_ph;
         end
         CMD_LOAD: if (sel) begin
            hp_in = ctl.hp;
            ph_in = '0;
         end
         CMD_ADVANCE: if (active) work_in = {1'b0, ph_ff} + {5'd0, ctl.elapsed};
         CMD_REDUCE: if (active) begin
            work_in = red;
            if (ctl.shift == 5'd0) ph_in = red[PH_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff   <= '0;
         ph_ff   <= '0;
         work_ff <= '0;
      end else begin
         hp_ff   <= hp_in;
         ph_ff   <= ph_in;
         work_ff <= work_in;
      end
   end

   assign hp    = hp_ff;
   assign ph    = ph_ff;
   assign match = active && (hp_ff == ctl.hp);
   assign level = ph_ff < {1'b0, hp_ff};
endmodule

// ===== rtl/polyphonic_square_tone_mixer.sv =====
// ---------------------------------------------------------------------------
// polyphonic_square_tone_mixer
// Square-tone table with add, delete, contains, clear and sample.
// ---------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | req_type (mode, freq, elapsed_us)
// rsp     | out | rsp_type (accepted, sample, note_count)
// Add, delete and contains with a nonzero freq wait on the
// one-bit-a-cycle divider; a sample on a non-empty table waits on
// the seventeen-step phase reduction. One item at a time.
// Reset clears the table at once. A stalled response holds in rsp; the
// next item is taken while it waits.
module polyphonic_square_tone_mixer #(
   parameter int MAX_NOTES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pstm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pstm_pkg::rsp_type rsp_data
);
   import pstm_pkg::*;
   `include "polyphonic_square_tone_mixer_macros.svh"

   localparam int CW = $clog2(MAX_NOTES + 1);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_OP, S_SUM, S_WAIT, S_MOD} state_type;

   state_type       state_ff;
   req_type         req_ff;
   cell_ctl_type    ctl;
   logic [CW-1:0]   count_ff;
   logic            acc_ff;
   logic [7:0]      wave_ff;
   logic            out_pend_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;
   logic [HP_W-1:0] hp_ff;
   logic [4:0]      shift_ff;
   logic            div_start, div_done;
   logic [HP_W-1:0] div_hp;

   logic [HP_W-1:0] c_hp [MAX_NOTES];
   logic [PH_W-1:0] c_ph [MAX_NOTES];
   logic [MAX_NOTES-1:0] c_match, c_level, c_act, c_sel;
   logic [MAX_NOTES-1:0] after_match;
   logic            found;
   logic [7:0]      wave_sum;

   pstm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .freq(req_data.freq),
      .done(div_done), .hp(div_hp)
   );

   // active and selection masks along the chain
   always_comb begin
      after_match = '0;
      for (int i = 0; i < MAX_NOTES; i++) begin
         c_act[i] = (i < int'(count_ff));
         if (i > 0) after_match[i] = after_match[i-1] | c_match[i-1];
         else       after_match[i] = 1'b0;
      end
      found = |c_match;
      wave_sum = 8'd128;
      for (int i = 0; i < MAX_NOTES; i++)
         if (c_act[i]) wave_sum = c_level[i] ? wave_sum + 8'd1 : wave_sum - 8'd1;
   end

   always_comb begin
      ctl.cmd     = CMD_NONE;
      ctl.hp      = hp_ff;
      ctl.elapsed = req_ff.elapsed_us;
      ctl.shift   = shift_ff;
      c_sel       = '0;
      if (state_ff == S_OP) begin
         priority case (1'b1)
            req_ff.mode == MODE_ADD && !found && int'(count_ff) < MAX_NOTES: begin
               ctl.cmd = CMD_LOAD;
               for (int i = 0; i < MAX_NOTES; i++) c_sel[i] = (i == int'(count_ff));
            end
            req_ff.mode == MODE_DELETE && found: begin
               ctl.cmd = CMD_SHIFT;
               c_sel   = after_match | c_match;
            end
            default: ;
         endcase
      end else if (state_ff == S_MOD) begin
         ctl.cmd = CMD_REDUCE;
      end else if (state_ff == S_DIV && req_ff.mode == MODE_CLEAR) begin
         ctl.cmd = CMD_CLEAR;
      end else if (state_ff == S_DIV && req_ff.mode == MODE_SAMPLE) begin
         ctl.cmd = CMD_ADVANCE;
      end
   end

   for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
      logic [HP_W-1:0] nh;
      logic [PH_W-1:0] np;
      if (g == MAX_NOTES - 1) begin : g_last
         assign nh = '0;
         assign np = '0;
      end else begin : g_mid
         assign nh = c_hp[g+1];
         assign np = c_ph[g+1];
      end
      pstm_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .sel(c_sel[g]),
         .active(c_act[g]), .next_hp(nh), .next_ph(np), .hp(c_hp[g]),
         .ph(c_ph[g]), .match(c_match[g]), .level(c_level[g])
      );
   end

   assign req_ready = (state_ff == S_IDLE) && !out_pend_ff;
   assign div_start = (state_ff == S_IDLE) && req_valid && req_ready
                      && req_data.mode <= MODE_CONTAINS && req_data.freq != 16'd0;

   // sequencer: take item, work it, queue response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= '0;
      end else begin
         if (out_pend_ff && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= '{acc_ff, wave_ff, 4'(count_ff)};
            out_pend_ff  <= 1'b0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               req_ff  <= req_data;
               acc_ff  <= 1'b0;
               wave_ff <= 8'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (req_ff.mode <= MODE_CONTAINS && req_ff.freq != 16'd0) begin
                  if (div_done) begin
                     hp_ff    <= div_hp;
                     state_ff <= S_WAIT;
                  end
               end else if (req_ff.mode == MODE_CLEAR) begin
                  count_ff    <= '0;
                  out_pend_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else if (req_ff.mode == MODE_SAMPLE && count_ff != '0) begin
                  shift_ff <= MOD_TOP_SHIFT;
                  state_ff <= S_MOD;
               end else begin
                  out_pend_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            // reduce the advanced phases, one shift of the period a cycle
            S_MOD: begin
               if (shift_ff == 5'd0) state_ff <= S_SUM;
               else shift_ff <= shift_ff - 5'd1;
            end
            S_WAIT: state_ff <= S_OP;
            S_OP: begin
               if (ctl.cmd == CMD_LOAD) begin
                  count_ff <= count_ff + CW'(1);
                  acc_ff   <= 1'b1;
               end else if (ctl.cmd == CMD_SHIFT) begin
                  count_ff <= count_ff - CW'(1);
                  acc_ff   <= 1'b1;
               end else if (req_ff.mode == MODE_CONTAINS) begin
                  acc_ff <= found;
               end
               out_pend_ff <= 1'b1;
               state_ff    <= S_IDLE;
            end
            S_SUM: begin
               wave_ff     <= wave_sum;
               out_pend_ff <= 1'b1;
               state_ff    <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PSTM_ASSERT_IMP(a_count_max, clock, reset, 1'b1, int'(count_ff) <= MAX_NOTES)
   `PSTM_ASSERT_IMP(a_one_match, clock, reset, state_ff == S_OP, $onehot0(c_match))
   `PSTM_ASSERT_NEXT(a_pend_idle, clock, reset, out_pend_ff && !rsp_valid_ff,
                     rsp_valid_ff)
endmodule
